/* rtl/fit_policy_block_allocator_assert.svh */
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define FPBA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("fpba assertion failed");

// next-cycle implication under synchronous active-low reset
`define FPBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("fpba assertion failed");

`endif

/* rtl/fpba_pkg.sv */
package fpba_pkg;

  localparam int BLOCKS_DEF     = 16;
  localparam int SIZE_WIDTH_DEF = 16;

  localparam int OP_W     = 1;
  localparam int BIDX_W   = 4;
  localparam int SVAL_W   = 16;
  localparam int MODE_W   = 2;
  localparam int BCNT_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 5;

  localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
  localparam logic [OP_W-1:0] OP_REQUEST = 1'b1;

  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd1;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

  localparam logic [MODE_W-1:0] FIT_MODE_RST    = FIT_FIRST;
  localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } fpba_state_t;

endpackage

/* rtl/fit_policy_block_allocator.sv */
// Fit-policy block allocator.
// Input channel (in_valid/in_ready) takes load and request items. A load
// writes one entry of the free-size table in its accept cycle and gives no
// result. A request scans entries 0 .. limit-1 (limit = block_count capped at
// BLOCKS) through one RAM read port and one compare unit, one entry a cycle,
// then writes back the chosen entry and loads the output register.
// A request is accepted in idle, scanned in the scan state and finished in the
// write-back state; the next item is taken only once the block is back in
// idle. The scan length, set by the single RAM read port, sets the rate.
// Config channel (cfg_valid/cfg_ready) is always ready; index 0 fit_mode,
// index 1 block_count. Write it only while the block is idle.
// Output channel (out_valid/out_ready) holds its item until taken. A stalled
// receiver holds the block in its write-back state, so no new item is taken.
// Reset (rst_n low, synchronous) returns to idle, clears out_valid and sets
// fit_mode to first fit and block_count to 16. Table contents are not
// cleared; entries must be loaded before they are searched.
module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int BLOCKS     = BLOCKS_DEF,
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_op,
  input  logic [BIDX_W-1:0]    in_block_index,
  input  logic [SVAL_W-1:0]    in_size_value,
  input  logic                 in_final_request,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_granted,
  output logic [BIDX_W-1:0]    out_chosen_block,
  output logic [SVAL_W-1:0]    out_fragment_left,
  output logic                 out_batch_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(BLOCKS);
  localparam int CNT_W = $clog2(BLOCKS + 1);
  localparam int LW    = (CNT_W > BCNT_W) ? CNT_W : BCNT_W;

  fpba_state_t state_r, state_nxt;

  logic [MODE_W-1:0]     fit_mode_r;
  logic [BCNT_W-1:0]     block_count_r;
  logic [CNT_W-1:0]      limit_r, limit_nxt;
  logic [CNT_W-1:0]      scan_ptr_r, scan_ptr_nxt;
  logic                  cmp_vld_r;
  logic [IDX_W-1:0]      cmp_idx_r;
  logic [SIZE_WIDTH-1:0] req_r, req_nxt;
  logic                  fin_r, fin_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      pick_r, pick_nxt;
  logic [SIZE_WIDTH-1:0] best_r, best_nxt;
  logic                  out_valid_r;
  logic                  out_granted_r;
  logic [BIDX_W-1:0]     out_chosen_r;
  logic [SVAL_W-1:0]     out_frag_r;
  logic                  out_batch_r;

  logic                  in_fire, load_fire, req_fire, load_hit;
  logic                  issue, fire_out, fit, better, take;
  logic [LW-1:0]         bc_ext, blocks_ext;
  logic [IDX_W+BIDX_W-1:0]      load_idx_ext;
  logic [IDX_W-1:0]             load_addr;
  logic [SIZE_WIDTH+SVAL_W-1:0] size_ext;
  logic [SIZE_WIDTH-1:0]        size_in;
  logic [SIZE_WIDTH-1:0]        frag;
  logic [SIZE_WIDTH+SVAL_W-1:0] frag_ext;
  logic [IDX_W+BIDX_W-1:0]      pick_ext;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [SIZE_WIDTH-1:0] ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [SIZE_WIDTH-1:0] ram_rdata;

  fpba_ram #(
    .WIDTH(SIZE_WIDTH),
    .DEPTH(BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_fire      = in_valid && in_ready;
  assign load_fire    = in_fire && (in_op == OP_LOAD);
  assign req_fire     = in_fire && (in_op == OP_REQUEST);
  assign load_idx_ext = {{IDX_W{1'b0}}, in_block_index};
  assign load_addr    = load_idx_ext[IDX_W-1:0];
  assign load_hit     = load_idx_ext < (IDX_W + BIDX_W)'(BLOCKS);
  assign size_ext     = {{SIZE_WIDTH{1'b0}}, in_size_value};
  assign size_in      = size_ext[SIZE_WIDTH-1:0];

  assign bc_ext     = LW'(block_count_r);
  assign blocks_ext = LW'(BLOCKS);

  always_comb begin
    if (bc_ext > blocks_ext) begin
      limit_nxt = blocks_ext[CNT_W-1:0];
    end else begin
      limit_nxt = bc_ext[CNT_W-1:0];
    end
  end

  assign issue    = (state_r == ST_SCAN) && (scan_ptr_r < limit_r);
  assign fire_out = (state_r == ST_WRITE) && (!out_valid_r || out_ready);

  assign fit    = ram_rdata >= req_r;
  assign better = !found_r
               || ((fit_mode_r == FIT_WORST) && (ram_rdata > best_r))
               || ((fit_mode_r == FIT_BEST) && (ram_rdata < best_r));
  assign take   = cmp_vld_r && fit && better;

  assign frag     = best_r - req_r;
  assign frag_ext = {{SVAL_W{1'b0}}, frag};
  assign pick_ext = {{BIDX_W{1'b0}}, pick_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req_fire) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue && !cmp_vld_r) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (fire_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = load_addr;
    ram_wdata = size_in;
    ram_raddr = scan_ptr_r[IDX_W-1:0];
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ram_we   = load_fire && load_hit;
      end
      ST_SCAN: begin
        ram_we = 1'b0;
      end
      ST_WRITE: begin
        ram_we    = fire_out && found_r;
        ram_waddr = pick_r;
        ram_wdata = frag;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    scan_ptr_nxt = scan_ptr_r;
    req_nxt      = req_r;
    fin_nxt      = fin_r;
    found_nxt    = found_r;
    pick_nxt     = pick_r;
    best_nxt     = best_r;
    if (req_fire) begin
      scan_ptr_nxt = '0;
      req_nxt      = size_in;
      fin_nxt      = in_final_request;
      found_nxt    = 1'b0;
    end else begin
      if (issue) begin
        scan_ptr_nxt = scan_ptr_r + 1'b1;
      end
      if (take) begin
        found_nxt = 1'b1;
        pick_nxt  = cmp_idx_r;
        best_nxt  = ram_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      fit_mode_r    <= FIT_MODE_RST;
      block_count_r <= BLOCK_COUNT_RST;
      cmp_vld_r     <= 1'b0;
      found_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= issue;
      found_r   <= found_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FIT_MODE:    fit_mode_r    <= cfg_data[MODE_W-1:0];
          CFG_BLOCK_COUNT: block_count_r <= cfg_data[BCNT_W-1:0];
          default:         fit_mode_r    <= fit_mode_r;
        endcase
      end
      if (fire_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr_r <= scan_ptr_nxt;
    cmp_idx_r  <= scan_ptr_r[IDX_W-1:0];
    req_r      <= req_nxt;
    fin_r      <= fin_nxt;
    pick_r     <= pick_nxt;
    best_r     <= best_nxt;
    if (req_fire) begin
      limit_r <= limit_nxt;
    end
    if (fire_out) begin
      out_granted_r <= found_r;
      out_chosen_r  <= found_r ? pick_ext[BIDX_W-1:0] : '0;
      out_frag_r    <= found_r ? frag_ext[SVAL_W-1:0] : '0;
      out_batch_r   <= fin_r;
    end
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_granted       = out_granted_r;
  assign out_chosen_block  = out_chosen_r;
  assign out_fragment_left = out_frag_r;
  assign out_batch_end     = out_batch_r;

`include "fit_policy_block_allocator_assert.svh"

  `FPBA_ASSERT_NOW(a_nogrant_zero, clk, rst_n, out_valid && !out_granted, (out_chosen_block == '0) && (out_fragment_left == '0))
  `FPBA_ASSERT_NEXT(a_req_scans, clk, rst_n, req_fire, (state_r == ST_SCAN) && !found_r)
  `FPBA_ASSERT_NOW(a_pick_in_range, clk, rst_n, (state_r == ST_WRITE) && found_r, CNT_W'(pick_r) < limit_r)
  `FPBA_ASSERT_NOW(a_no_write_in_scan, clk, rst_n, state_r == ST_SCAN, !ram_we && !in_ready)

endmodule

/* rtl/fpba_ram.sv */
module fpba_ram
  import fpba_pkg::*;
#(
  parameter int WIDTH = SIZE_WIDTH_DEF,
  parameter int DEPTH = BLOCKS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/fit_policy_block_allocator_test.sv */
`timescale 1ns / 100ps

module fit_policy_block_allocator_test;
  import fpba_pkg::*;

  localparam logic [MODE_W-1:0] FIT_SPARE = 2'd3;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 130;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [BIDX_W-1:0] idx;
    logic [SVAL_W-1:0] size;
    logic              fin;
  } alloc_item_t;

  typedef struct packed {
    logic              granted;
    logic [BIDX_W-1:0] block;
    logic [SVAL_W-1:0] frag;
    logic              batch_end;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_op = OP_LOAD;
  logic [BIDX_W-1:0] in_block_index = '0;
  logic [SVAL_W-1:0] in_size_value = '0;
  logic in_final_request = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_granted;
  logic [BIDX_W-1:0] out_chosen_block;
  logic [SVAL_W-1:0] out_fragment_left;
  logic out_batch_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FIT_MODE;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  alloc_item_t pending[$];
  alloc_item_t next_item;
  grant_t grants_due[$];
  grant_t got;

  logic [SVAL_W-1:0] free_size [BLOCKS_DEF];
  logic [MODE_W-1:0] fit_mode_m = FIT_MODE_RST;
  logic [BCNT_W-1:0] block_count_m = BLOCK_COUNT_RST;
  logic [SVAL_W-1:0] last_load = '0;

  bit in_taken = 1'b0;
  bit calm = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_asks = 0;
  int hold_taken = 0;
  int cfg_writes = 0;
  int errors = 0;
  int unsigned cycle_count = 0;

  fit_policy_block_allocator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_block_index(in_block_index),
    .in_size_value(in_size_value),
    .in_final_request(in_final_request),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_granted(out_granted),
    .out_chosen_block(out_chosen_block),
    .out_fragment_left(out_fragment_left),
    .out_batch_end(out_batch_end),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic grant_t allocate(input logic [SVAL_W-1:0] need, input logic fin);
    grant_t g;
    int span;
    int pick;
    bit hit;
    bit done;
    g = '0;
    pick = 0;
    hit = 1'b0;
    done = 1'b0;
    span = (block_count_m > BLOCKS_DEF) ? BLOCKS_DEF : int'(block_count_m);
    for (int j = 0; j < span; j++) begin
      if (!done && free_size[j] >= need) begin
        if (!hit) begin
          hit = 1'b1;
          pick = j;
          done = (fit_mode_m != FIT_WORST) && (fit_mode_m != FIT_BEST);
        end else if (fit_mode_m == FIT_WORST && free_size[j] > free_size[pick]) begin
          pick = j;
        end else if (fit_mode_m == FIT_BEST && free_size[j] < free_size[pick]) begin
          pick = j;
        end
      end
    end
    if (hit) begin
      free_size[pick] = free_size[pick] - need;
      g.granted = 1'b1;
      g.block = pick[BIDX_W-1:0];
      g.frag = free_size[pick];
    end
    g.batch_end = fin;
    return g;
  endfunction

  function automatic logic [SVAL_W-1:0] draw_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return SVAL_W'($urandom_range(0, 255));
      5, 6, 7: return SVAL_W'($urandom_range(0, 4095));
      default: return SVAL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_item(input logic [OP_W-1:0] op, input logic [BIDX_W-1:0] idx,
                           input logic [SVAL_W-1:0] size, input logic fin);
    alloc_item_t it;
    it.op = op;
    it.idx = idx;
    it.size = size;
    it.fin = fin;
    pending.push_back(it);
  endtask

  task automatic push_random(input int n);
    logic [SVAL_W-1:0] v;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          v = last_load;
        end else if ($urandom_range(0, 1) == 1) begin
          v = SVAL_W'($urandom_range(0, 65535));
        end else begin
          v = draw_size();
        end
        last_load = v;
        push_item(OP_LOAD, BIDX_W'($urandom_range(0, 15)), v, 1'($urandom_range(0, 1)));
      end else begin
        push_item(OP_REQUEST, BIDX_W'($urandom_range(0, 15)), draw_size(),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic settle();
    while (pending.size() != 0 || in_valid || grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_policy(input logic [MODE_W-1:0] mode, input logic [BCNT_W-1:0] count);
    int seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FIT_MODE;
    cfg_data <= CFG_DAT_W'(mode);
    do @(negedge clk); while (cfg_writes == seen);
    seen = cfg_writes;
    cfg_index <= CFG_BLOCK_COUNT;
    cfg_data <= count;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  // sender: hold until taken, then idle in bursts or offer the next item
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      in_valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      gap_left = $urandom_range(0, 4);
      in_valid <= 1'b0;
    end else if (pending.size() != 0) begin
      next_item = pending.pop_front();
      in_valid <= 1'b1;
      in_op <= next_item.op;
      in_block_index <= next_item.idx;
      in_size_value <= next_item.size;
      in_final_request <= next_item.fin;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: long hold on request, else short random stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_taken != hold_asks) begin
      hold_taken = hold_asks;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FIT_MODE) begin
          fit_mode_m = cfg_data[MODE_W-1:0];
        end else if (cfg_index == CFG_BLOCK_COUNT) begin
          block_count_m = cfg_data[BCNT_W-1:0];
        end
        cfg_writes = cfg_writes + 1;
      end
      if (in_taken) begin
        if (in_op == OP_LOAD) begin
          free_size[in_block_index] = in_size_value;
        end else begin
          grants_due.push_back(allocate(in_size_value, in_final_request));
        end
      end
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          $error("result with no pending request");
          errors = errors + 1;
        end else begin
          got = grants_due.pop_front();
          if (out_granted !== got.granted) begin
            $error("granted: expected %0d, got %0d", got.granted, out_granted);
            errors = errors + 1;
          end
          if (out_chosen_block !== got.block) begin
            $error("chosen_block: expected %0d, got %0d", got.block, out_chosen_block);
            errors = errors + 1;
          end
          if (out_fragment_left !== got.frag) begin
            $error("fragment_left: expected %0d, got %0d", got.frag, out_fragment_left);
            errors = errors + 1;
          end
          if (out_batch_end !== got.batch_end) begin
            $error("batch_end: expected %0d, got %0d", got.batch_end, out_batch_end);
            errors = errors + 1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [MODE_W-1:0] modes [PHASES];
    logic [BCNT_W-1:0] counts [PHASES];
    logic [SVAL_W-1:0] v;
    modes = '{FIT_WORST, FIT_BEST, FIT_FIRST, FIT_BEST, FIT_SPARE,
              FIT_WORST, FIT_BEST, FIT_FIRST, FIT_WORST, FIT_BEST};
    counts = '{5'd16, 5'd16, 5'd1, 5'd7, 5'd16, 5'd0, 5'd31, 5'd17, 5'd5, 5'd16};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // fill every entry before the first request
    for (int i = 0; i < BLOCKS_DEF; i++) begin
      case (i)
        0, 4: v = 16'd100;
        1, 5: v = 16'hFFFF;
        2: v = 16'd0;
        3: v = 16'd500;
        default: v = SVAL_W'(i * 1000 + 7);
      endcase
      push_item(OP_LOAD, BIDX_W'(i), v, i == 7);
    end
    push_item(OP_REQUEST, 4'hF, 16'd0, 1'b0);
    push_item(OP_REQUEST, 4'h0, 16'd100, 1'b0);
    push_item(OP_REQUEST, 4'hF, 16'hFFFF, 1'b0);
    push_item(OP_REQUEST, 4'h0, 16'hFFFF, 1'b0);
    push_item(OP_REQUEST, 4'hF, 16'hFFFF, 1'b1);
    push_item(OP_REQUEST, 4'h0, 16'd1, 1'b1);
    push_item(OP_REQUEST, 4'hF, 16'd40000, 1'b0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      set_policy(modes[p], counts[p]);
      calm = (p == PHASES - 1);
      push_random(PHASE_ITEMS);
      if (p == 1) begin
        hold_asks = hold_asks + 1;
      end
      settle();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/fpba_pkg.sv
rtl/fpba_ram.sv
rtl/fit_policy_block_allocator.sv
tb/fit_policy_block_allocator_test.sv
